// File: sv/sad_pkg.sv
// shared types and constants for the spectral angle detector
package sad_pkg;

	// field widths
	localparam int SAMPLE_W = 16;
	localparam int BANDS_W  = 9;
	localparam int THRESH_W = 17;
	localparam int SCORE_W  = 17;
	localparam int HIT_W    = 24;
	localparam int FRAC_W   = 16;

	// configuration port
	localparam int CFG_IW = 1;
	localparam int CFG_DW = 17;
	localparam logic [CFG_IW-1:0] REG_BANDS  = 1'd0;
	localparam logic [CFG_IW-1:0] REG_THRESH = 1'd1;

	// reset values and limits
	localparam logic [BANDS_W-1:0]  BANDS_RESET  = 9'd191;
	localparam logic [THRESH_W-1:0] THRESH_RESET = 17'd64881;
	localparam logic [SCORE_W-1:0]  SCORE_ONE    = 17'd65536;
	localparam logic [HIT_W-1:0]    HIT_MAX      = 24'hFFFFFF;

	// item kinds
	localparam logic KIND_TARGET = 1'b0;
	localparam logic KIND_PIXEL  = 1'b1;

	// finish unit sequencer
	typedef enum logic [1:0] {
		FIN_IDLE,
		FIN_MUL,
		FIN_DIV,
		FIN_OUT
	} fin_state_t;

endpackage

// File: sv/sad_target_mem.sv
// target spectrum store, one write port and one registered read port
module sad_target_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [sad_pkg::SAMPLE_W-1:0]  wr_data,
	input  logic                          rd_en,
	input  logic [AW-1:0]                 rd_addr,
	output logic [sad_pkg::SAMPLE_W-1:0]  rd_data
);
	import sad_pkg::*;

	logic [SAMPLE_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: sv/sad_front.sv
// band intake: store pointer, band counter, products and running sums
module sad_front #(
	parameter int MAX_BANDS = 256,
	parameter int AD        = 8,
	parameter int NW        = 9,
	parameter int EW        = 39,
	parameter int CW        = 40
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [NW-1:0]                     n_eff,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              kind,
	input  logic signed [sad_pkg::SAMPLE_W-1:0] sample,
	input  logic                              fin_busy,
	output logic                              go,
	output logic signed [CW-1:0]              cross_sum,
	output logic [EW-1:0]                     target_energy,
	output logic [EW-1:0]                     pixel_energy
);
	import sad_pkg::*;

	logic              loading_q;
	logic [NW-1:0]     lptr_q;
	logic [AD-1:0]     bcnt_q;

	logic              v_s1, kind_s1, first_s1, last_s1, wr_s1, tstart_s1;
	logic signed [SAMPLE_W-1:0] x_s1;
	logic [SAMPLE_W-1:0] rd_data;

	logic              v_s2, kind_s2, first_s2, last_s2, wr_s2, tstart_s2;
	logic signed [31:0] psx_s2;
	logic [30:0]       pxx_s2;

	logic signed [CW-1:0] cs_q;
	logic [EW-1:0]     te_q, pe_q;
	logic              go_q;

	logic              acc, last_cond, wr_ok, blk;
	logic [NW-1:0]     ptr_eff;
	logic signed [31:0] sx_prod, xx_prod;
	logic signed [SAMPLE_W-1:0] s_rd;
	logic signed [CW-1:0] cs_base, sx_ext;
	logic [EW-1:0]     te_base, pe_base;

	// intake decisions
	assign last_cond = (NW'(bcnt_q) + NW'(1)) >= n_eff;
	assign ptr_eff   = loading_q ? lptr_q : '0;
	assign wr_ok     = ptr_eff < n_eff;
	assign blk       = fin_busy | (v_s1 & last_s1) | (v_s2 & last_s2) | go_q;
	assign in_ready  = !((kind == KIND_PIXEL) && last_cond) || !blk;
	assign acc       = in_valid & in_ready;

	sad_target_mem #(
		.DEPTH(MAX_BANDS),
		.AW   (AD)
	) u_mem (
		.clk    (clk),
		.wr_en  (acc && (kind == KIND_TARGET) && wr_ok),
		.wr_addr(ptr_eff[AD-1:0]),
		.wr_data(sample),
		.rd_en  (acc && (kind == KIND_PIXEL)),
		.rd_addr(bcnt_q),
		.rd_data(rd_data)
	);

	// pointer, band counter and loading run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loading_q <= 1'b0;
			lptr_q    <= '0;
			bcnt_q    <= '0;
		end else if (acc) begin
			if (kind == KIND_TARGET) begin
				loading_q <= 1'b1;
				lptr_q    <= wr_ok ? ptr_eff + NW'(1) : ptr_eff;
				if (!loading_q) begin
					bcnt_q <= '0;
				end
			end else begin
				loading_q <= 1'b0;
				bcnt_q    <= last_cond ? '0 : bcnt_q + AD'(1);
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			v_s1    <= acc;
			last_s1 <= acc && (kind == KIND_PIXEL) && last_cond;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		kind_s1   <= kind;
		x_s1      <= sample;
		first_s1  <= bcnt_q == '0;
		wr_s1     <= wr_ok;
		tstart_s1 <= !loading_q;
	end

	// stage 2 products
	assign s_rd    = rd_data;
	assign sx_prod = x_s1 * s_rd;
	assign xx_prod = x_s1 * x_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			v_s2    <= v_s1;
			last_s2 <= v_s1 & last_s1;
		end
	end

	always_ff @(posedge clk) begin
		kind_s2   <= kind_s1;
		first_s2  <= first_s1;
		wr_s2     <= wr_s1;
		tstart_s2 <= tstart_s1;
		psx_s2    <= sx_prod;
		pxx_s2    <= xx_prod[30:0];
	end

	// stage 3 running sums
	assign sx_ext  = CW'(psx_s2);
	assign cs_base = first_s2 ? '0 : cs_q;
	assign pe_base = first_s2 ? '0 : pe_q;
	assign te_base = tstart_s2 ? '0 : te_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q <= '0;
			pe_q <= '0;
			te_q <= '0;
			go_q <= 1'b0;
		end else begin
			go_q <= v_s2 & last_s2;
			if (v_s2) begin
				if (kind_s2 == KIND_PIXEL) begin
					cs_q <= cs_base + sx_ext;
					pe_q <= pe_base + EW'(pxx_s2);
				end else if (wr_s2) begin
					te_q <= te_base + EW'(pxx_s2);
				end
			end
		end
	end

	assign go            = go_q;
	assign cross_sum     = cs_q;
	assign target_energy = te_q;
	assign pixel_energy  = pe_q;

endmodule

// File: sv/sad_finish.sv
// per-pixel score: serial squaring and energy product, then restoring division
module sad_finish #(
	parameter int EW = 39,
	parameter int CW = 40
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             go,
	input  logic signed [CW-1:0]             cross_sum,
	input  logic [EW-1:0]                    target_energy,
	input  logic [EW-1:0]                    pixel_energy,
	input  logic [sad_pkg::THRESH_W-1:0]     thresh,
	output logic                             busy,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [sad_pkg::SCORE_W-1:0]      score,
	output logic                             detected,
	output logic                             zero_energy,
	output logic [sad_pkg::HIT_W-1:0]        detected_total
);
	import sad_pkg::*;

	localparam int PW   = 2 * EW;
	localparam int NUMW = PW + FRAC_W;
	localparam int CTW  = $clog2(EW);

	fin_state_t state_q, state_nx;

	logic [PW-1:0]   mca_q, mcd_q, pa_q, pd_q, pa_nx, pd_nx;
	logic [EW-1:0]   mpa_q, mpd_q;
	logic [CTW-1:0]  cnt_q;
	logic [NUMW-1:0] rem_q, dsh_q, rem_nx;
	logic [SCORE_W-1:0] q_q, q_nx;
	logic            take, zero_q, det_nx, mul_end, div_end;
	logic [CW-1:0]   cs_neg;
	logic [EW-1:0]   cs_mag;
	logic [SCORE_W-1:0] score_q;
	logic            det_q;
	logic [HIT_W-1:0] hit_q;

	assign cs_neg  = -cross_sum;
	assign cs_mag  = cross_sum[CW-1] ? cs_neg[EW-1:0] : cross_sum[EW-1:0];
	assign mul_end = cnt_q == CTW'(EW - 1);
	assign div_end = cnt_q == CTW'(FRAC_W);

	// shift-add steps
	assign pa_nx = mpa_q[0] ? pa_q + mca_q : pa_q;
	assign pd_nx = mpd_q[0] ? pd_q + mcd_q : pd_q;

	// restoring division step
	assign take   = dsh_q <= rem_q;
	assign rem_nx = take ? rem_q - dsh_q : rem_q;
	assign q_nx   = {q_q[SCORE_W-2:0], take};
	assign det_nx = (q_nx > thresh) || ((q_nx == thresh) && (rem_nx != '0));

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FIN_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx  = state_q;
		busy      = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			FIN_IDLE: begin
				busy = 1'b0;
				if (go) begin
					state_nx = FIN_MUL;
				end
			end
			FIN_MUL: begin
				if (mul_end) begin
					state_nx = FIN_DIV;
				end
			end
			FIN_DIV: begin
				if (div_end) begin
					state_nx = FIN_OUT;
				end
			end
			FIN_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_nx = FIN_IDLE;
				end
			end
			default: begin
				state_nx = FIN_IDLE;
			end
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			FIN_IDLE: begin
				mca_q  <= PW'(cs_mag);
				mpa_q  <= cs_mag;
				pa_q   <= '0;
				mcd_q  <= PW'(target_energy);
				mpd_q  <= pixel_energy;
				pd_q   <= '0;
				cnt_q  <= '0;
				zero_q <= (target_energy == '0) || (pixel_energy == '0);
			end
			FIN_MUL: begin
				pa_q  <= pa_nx;
				pd_q  <= pd_nx;
				mca_q <= mca_q << 1;
				mcd_q <= mcd_q << 1;
				mpa_q <= mpa_q >> 1;
				mpd_q <= mpd_q >> 1;
				if (mul_end) begin
					rem_q <= {pa_nx, {FRAC_W{1'b0}}};
					dsh_q <= {pd_nx, {FRAC_W{1'b0}}};
					q_q   <= '0;
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + CTW'(1);
				end
			end
			FIN_DIV: begin
				rem_q <= rem_nx;
				dsh_q <= dsh_q >> 1;
				q_q   <= q_nx;
				cnt_q <= cnt_q + CTW'(1);
				if (div_end) begin
					score_q <= zero_q ? '0 : ((q_nx > SCORE_ONE) ? SCORE_ONE : q_nx);
					det_q   <= det_nx & !zero_q;
				end
			end
			default: begin
			end
		endcase
	end

	// saturating count of detected pixels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= '0;
		end else if ((state_q == FIN_DIV) && div_end && det_nx && !zero_q
				&& (hit_q != HIT_MAX)) begin
			hit_q <= hit_q + HIT_W'(1);
		end
	end

	assign score          = score_q;
	assign detected       = det_q;
	assign zero_energy    = zero_q;
	assign detected_total = hit_q;

endmodule

// File: sv/spectral_angle_detector.sv
// top level: squared-cosine spectral angle detector
// band items: one per cycle while in_ready is high; sums follow the registered products
// result: serial shift-add multiply, then restoring division, after the last band is summed
// a pixel's last band waits for the previous result to be taken
// reset: asynchronous, clears pointers, sums, count and config to defaults
// target store is not cleared by reset; a target must be loaded before pixels
module spectral_angle_detector #(
	parameter int MAX_BANDS = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sad_pkg::CFG_IW-1:0]        cfg_index,
	input  logic [sad_pkg::CFG_DW-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              kind,
	input  logic signed [sad_pkg::SAMPLE_W-1:0] sample,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sad_pkg::SCORE_W-1:0]       score,
	output logic                              detected,
	output logic                              zero_energy,
	output logic [sad_pkg::HIT_W-1:0]         detected_total
);
	import sad_pkg::*;

	localparam int AD = $clog2(MAX_BANDS);
	localparam int NW = AD + 1;
	localparam int XW = (NW > BANDS_W) ? NW : BANDS_W;
	localparam int EW = 2 * SAMPLE_W - 1 + AD;
	localparam int CW = EW + 1;

	logic [BANDS_W-1:0]  bands_q;
	logic [THRESH_W-1:0] thresh_q;
	logic [XW-1:0]       bands_x;
	logic [NW-1:0]       n_eff;

	logic                fin_go, fin_busy;
	logic signed [CW-1:0] cross_sum;
	logic [EW-1:0]       target_energy, pixel_energy;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bands_q  <= BANDS_RESET;
			thresh_q <= THRESH_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BANDS:  bands_q  <= cfg_data[BANDS_W-1:0];
				REG_THRESH: thresh_q <= cfg_data[THRESH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// effective band count, clamped to one and to the store depth
	assign bands_x = XW'(bands_q);
	assign n_eff   = (bands_q == '0) ? NW'(1)
			: ((bands_x > XW'(MAX_BANDS)) ? NW'(MAX_BANDS) : NW'(bands_x));

	sad_front #(
		.MAX_BANDS(MAX_BANDS),
		.AD       (AD),
		.NW       (NW),
		.EW       (EW),
		.CW       (CW)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.n_eff        (n_eff),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.sample       (sample),
		.fin_busy     (fin_busy),
		.go           (fin_go),
		.cross_sum    (cross_sum),
		.target_energy(target_energy),
		.pixel_energy (pixel_energy)
	);

	sad_finish #(
		.EW(EW),
		.CW(CW)
	) u_finish (
		.clk           (clk),
		.arst_n        (arst_n),
		.go            (fin_go),
		.cross_sum     (cross_sum),
		.target_energy (target_energy),
		.pixel_energy  (pixel_energy),
		.thresh        (thresh_q),
		.busy          (fin_busy),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.score         (score),
		.detected      (detected),
		.zero_energy   (zero_energy),
		.detected_total(detected_total)
	);

	// a finished pixel never finds the finish unit occupied
	assert property (@(posedge clk) disable iff (!arst_n) fin_go |-> !fin_busy)
		else $error("pixel sums handed over while finish unit busy");

	// zero energy forces a null score and no detection
	assert property (@(posedge clk) disable iff (!arst_n)
			(out_valid && zero_energy) |-> (score == '0 && !detected))
		else $error("zero energy result carries a score or detection");

	// a detected pixel is always counted
	assert property (@(posedge clk) disable iff (!arst_n)
			(out_valid && detected) |-> (detected_total != '0))
		else $error("detection without a count");

	// a result is shown only while the finish unit holds it
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> fin_busy)
		else $error("result valid with finish unit idle");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// testbench for the spectral angle detector: queued band items, squared-cosine predictor, result checks
module tb_top;
	import sad_pkg::*;

	localparam int NBANDS     = 256;
	localparam int DRAIN_GAP  = 2 * $clog2(NBANDS) + 82 + 20;
	localparam int RAND_ITEMS = 650;

	typedef struct packed {
		logic                kind;
		logic [SAMPLE_W-1:0] sample;
	} band_item_t;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic               detected;
		logic               zero_energy;
		logic [HIT_W-1:0]   detected_total;
	} pixel_result_t;

	// block ports
	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IW-1:0]          cfg_index = '0;
	logic [CFG_DW-1:0]          cfg_data  = '0;
	logic                       in_valid  = 1'b0;
	logic                       in_ready;
	logic                       kind      = KIND_TARGET;
	logic signed [SAMPLE_W-1:0] sample    = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [SCORE_W-1:0]         score;
	logic                       detected;
	logic                       zero_energy;
	logic [HIT_W-1:0]           detected_total;

	spectral_angle_detector #(.MAX_BANDS(NBANDS)) dut (.*);

	// predictor state
	logic signed [SAMPLE_W-1:0] tgt_store [NBANDS];
	longint unsigned            tgt_energy;
	longint unsigned            pix_energy;
	longint                     cross_acc;
	int                         load_ptr;
	int                         band_cnt;
	logic                       target_run;
	logic [HIT_W-1:0]           hit_cnt;
	logic [BANDS_W-1:0]         bands_reg;
	logic [THRESH_W-1:0]        thresh_reg;

	pixel_result_t expected_scores [$];
	band_item_t    pending_items [$];

	// generator bookkeeping
	logic signed [SAMPLE_W-1:0] gen_target [NBANDS];
	int                         gen_ptr       = 0;
	logic                       gen_last_kind = KIND_PIXEL;
	int                         pushed        = 0;

	// run statistics
	int idle_pct     = 20;
	int mismatches   = 0;
	int items_taken  = 0;
	int results_seen = 0;
	int cfg_writes   = 0;
	int det_pixels   = 0;
	int zero_pixels  = 0;

	always #4 clk = ~clk;

	function automatic int eff_bands(logic [BANDS_W-1:0] b);
		if (b == 0)
			return 1;
		if (b > NBANDS)
			return NBANDS;
		return int'(b);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return '0;
			3: return 16'($urandom_range(16) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] clamp16(int v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return v[SAMPLE_W-1:0];
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		mismatches++;
		if (mismatches <= 50)
			$display("mismatch at result %0d: %s got %0d, predicted %0d",
				results_seen, what, got, want);
	endtask

	// squared-cosine predictor, one accepted band item at a time
	task automatic predict_band(logic k, logic signed [SAMPLE_W-1:0] s);
		int            n;
		longint        xv;
		longint        tv;
		logic [127:0]  mag;
		logic [127:0]  num;
		logic [127:0]  den;
		logic [127:0]  quo;
		pixel_result_t r;
		n  = eff_bands(bands_reg);
		xv = s;
		if (k == KIND_TARGET) begin
			// first target item of a run restarts the store and drops any partial pixel
			if (!target_run) begin
				target_run = 1'b1;
				load_ptr   = 0;
				tgt_energy = 0;
				band_cnt   = 0;
				cross_acc  = 0;
				pix_energy = 0;
			end
			if (load_ptr < n) begin
				tgt_store[load_ptr] = s;
				tgt_energy += xv * xv;
				load_ptr++;
			end
		end else begin
			target_run = 1'b0;
			tv = (band_cnt < NBANDS) ? longint'(tgt_store[band_cnt]) : 0;
			cross_acc  += xv * tv;
			pix_energy += xv * xv;
			band_cnt++;
			// pixel ends once the counter reaches the band count
			if (band_cnt >= n) begin
				r = '0;
				if (tgt_energy == 0 || pix_energy == 0) begin
					r.zero_energy = 1'b1;
					zero_pixels++;
				end else begin
					mag = (cross_acc < 0) ? -cross_acc : cross_acc;
					num = (mag * mag) << FRAC_W;
					den = 128'(tgt_energy) * 128'(pix_energy);
					quo = num / den;
					r.score    = (quo > SCORE_ONE) ? SCORE_ONE : quo[SCORE_W-1:0];
					r.detected = (num > den * 128'(thresh_reg));
				end
				if (r.detected) begin
					det_pixels++;
					if (hit_cnt != HIT_MAX)
						hit_cnt++;
				end
				r.detected_total = hit_cnt;
				expected_scores.push_back(r);
				band_cnt   = 0;
				cross_acc  = 0;
				pix_energy = 0;
			end
		end
	endtask

	// register write, predictor follows at the accepting edge
	task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_BANDS)
			bands_reg = val[BANDS_W-1:0];
		else
			thresh_reg = val[THRESH_W-1:0];
		cfg_writes++;
	endtask

	// hold off until every queued item is taken and every result is back
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || in_valid || expected_scores.size() != 0);
		repeat (DRAIN_GAP) @(negedge clk);
	endtask

	task automatic push_band(logic k, logic signed [SAMPLE_W-1:0] s);
		band_item_t it;
		if (k == KIND_TARGET) begin
			if (gen_last_kind != KIND_TARGET)
				gen_ptr = 0;
			if (gen_ptr < NBANDS) begin
				gen_target[gen_ptr] = s;
				gen_ptr++;
			end
		end
		gen_last_kind = k;
		it.kind   = k;
		it.sample = s;
		pending_items.push_back(it);
		pushed++;
	endtask

	task automatic push_target(int len);
		logic small_vals;
		small_vals = ($urandom_range(4) == 0);
		for (int b = 0; b < len; b++)
			push_band(KIND_TARGET, small_vals ? 16'($urandom_range(16) - 8) : rand_sample());
	endtask

	// pixel shapes: random, noisy copy, scaled copy, negated copy, all zero
	task automatic push_pixel(int len, int style);
		int amp;
		int shift;
		int v;
		amp   = 1 << $urandom_range(14);
		shift = $urandom_range(6);
		for (int b = 0; b < len; b++) begin
			case (style)
				0: push_band(KIND_PIXEL, rand_sample());
				1: begin
					v = int'(gen_target[b]) + int'($urandom_range(2 * amp)) - amp;
					push_band(KIND_PIXEL, clamp16(v));
				end
				2: push_band(KIND_PIXEL, gen_target[b] >>> shift);
				3: push_band(KIND_PIXEL, clamp16(-int'(gen_target[b])));
				default: push_band(KIND_PIXEL, '0);
			endcase
		end
	endtask

	function automatic int pick_style();
		case ($urandom_range(9))
			0, 1, 2: return 0;
			3, 4, 5: return 1;
			6, 7:    return 2;
			8:       return 3;
			default: return 4;
		endcase
	endfunction

	// one randomized phase: new settings, then target and pixel sequences
	task automatic random_phase(logic big);
		int                n;
		int                nseq;
		int                r;
		int                len;
		logic [CFG_DW-1:0] bv;
		logic [CFG_DW-1:0] tv;
		r = $urandom_range(99);
		if (big)
			bv = CFG_DW'($urandom_range(511, 257));
		else if (r < 60)
			bv = CFG_DW'($urandom_range(8, 1));
		else if (r < 85)
			bv = CFG_DW'($urandom_range(40, 9));
		else
			bv = CFG_DW'($urandom_range(1));
		if ($urandom_range(3) == 0)
			bv[CFG_DW-1:BANDS_W] = 8'($urandom);
		case ($urandom_range(5))
			0: tv = '0;
			1: tv = SCORE_ONE;
			2: tv = THRESH_RESET;
			3: tv = CFG_DW'(SCORE_ONE - $urandom_range(3000));
			4: tv = CFG_DW'($urandom_range(131071, 65537));
			default: tv = CFG_DW'($urandom_range(65536));
		endcase
		if ($urandom_range(1)) begin
			write_reg(REG_BANDS, bv);
			write_reg(REG_THRESH, tv);
		end else begin
			write_reg(REG_THRESH, tv);
			write_reg(REG_BANDS, bv);
		end
		n = eff_bands(bands_reg);
		if (big) begin
			push_target(n);
			push_pixel(n, 1);
		end else begin
			nseq = $urandom_range(12, 4);
			for (int i = 0; i < nseq; i++) begin
				r = $urandom_range(99);
				if (r < 5) begin
					push_target(n + $urandom_range(3, 1));
				end else if (r < 8) begin
					len = (n > 1) ? $urandom_range(n - 1, 1) : n;
					push_target(len);
				end else if (r < 15) begin
					push_target(n);
				end else if (r < 85 || n == 1) begin
					push_pixel(n, pick_style());
				end else begin
					// partial pixel, later merged or dropped by a target run
					push_pixel($urandom_range(n - 1, 1), 0);
				end
			end
		end
	endtask

	// item driver
	always @(posedge clk) begin : drive_items
		band_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
				it = pending_items.pop_front();
				in_valid <= 1'b1;
				kind     <= it.kind;
				sample   <= it.sample;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// accepted items feed the predictor
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			predict_band(kind, sample);
			items_taken++;
		end
	end

	// result monitor with random back-pressure
	always @(posedge clk) begin : check_results
		pixel_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_scores.size() == 0) begin
					report_mismatch("result with nothing predicted", score, 0);
				end else begin
					want = expected_scores.pop_front();
					if (score !== want.score)
						report_mismatch("score", score, want.score);
					if (detected !== want.detected)
						report_mismatch("detected", detected, want.detected);
					if (zero_energy !== want.zero_energy)
						report_mismatch("zero_energy", zero_energy, want.zero_energy);
					if (detected_total !== want.detected_total)
						report_mismatch("detected_total", detected_total, want.detected_total);
				end
			end
			out_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// stimulus
	initial begin
		int directed_n;
		int phase;
		target_run = 1'b0;
		load_ptr   = 0;
		band_cnt   = 0;
		tgt_energy = 0;
		pix_energy = 0;
		cross_acc  = 0;
		hit_cnt    = '0;
		bands_reg  = BANDS_RESET;
		thresh_reg = THRESH_RESET;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// full-width target so every store entry holds a known value
		write_reg(REG_BANDS, NBANDS);
		write_reg(REG_THRESH, THRESH_RESET);
		push_target(NBANDS);
		wait_idle();

		// two-band extremes, zero energy on either side, overflow, dropped pixel
		write_reg(REG_BANDS, 2);
		push_band(KIND_TARGET, 16'sh7FFF);
		push_band(KIND_TARGET, 16'sh8000);
		push_band(KIND_PIXEL, 16'sh7FFF);
		push_band(KIND_PIXEL, 16'sh8000);
		push_band(KIND_PIXEL, 16'sh8000);
		push_band(KIND_PIXEL, 16'sh7FFF);
		push_band(KIND_PIXEL, 0);
		push_band(KIND_PIXEL, 0);
		push_band(KIND_TARGET, 0);
		push_band(KIND_TARGET, 0);
		push_band(KIND_PIXEL, 5);
		push_band(KIND_PIXEL, 7);
		push_band(KIND_TARGET, 3);
		push_band(KIND_TARGET, -4);
		push_band(KIND_TARGET, 100);
		push_band(KIND_TARGET, -200);
		push_band(KIND_PIXEL, 3);
		push_band(KIND_PIXEL, -4);
		push_band(KIND_PIXEL, 9);
		push_band(KIND_TARGET, 1);
		push_band(KIND_TARGET, 2);
		push_band(KIND_PIXEL, 2);
		push_band(KIND_PIXEL, 1);
		wait_idle();

		// band count lowered while a pixel is half done
		write_reg(REG_BANDS, 3);
		push_band(KIND_TARGET, 100);
		push_band(KIND_TARGET, 0);
		push_band(KIND_TARGET, -100);
		push_band(KIND_PIXEL, 100);
		push_band(KIND_PIXEL, 50);
		wait_idle();
		write_reg(REG_BANDS, 1);
		push_band(KIND_PIXEL, -100);
		push_band(KIND_PIXEL, 7);
		wait_idle();

		// zero band count acts as one, threshold at zero
		write_reg(REG_BANDS, 0);
		write_reg(REG_THRESH, 0);
		push_band(KIND_PIXEL, 16'sh8000);
		push_band(KIND_PIXEL, 1);
		wait_idle();

		// store holds more bands than the target energy covers, threshold at one
		write_reg(REG_BANDS, 4);
		write_reg(REG_THRESH, SCORE_ONE);
		push_band(KIND_PIXEL, 100);
		push_band(KIND_PIXEL, 0);
		push_band(KIND_PIXEL, -100);
		push_band(KIND_PIXEL, (gen_target[3] == 0) ? 16'sh7FFF : gen_target[3]);
		wait_idle();
		directed_n = pushed;

		// random phases, the one with the largest band count runs with no stalls
		phase = 0;
		while (pushed - directed_n < RAND_ITEMS) begin
			idle_pct = (phase == 1) ? 0 : 20;
			random_phase(phase == 1);
			wait_idle();
			phase++;
		end
		idle_pct = 20;
		repeat (200) @(negedge clk);

		if (expected_scores.size() != 0)
			report_mismatch("predictions never answered", expected_scores.size(), 0);
		$display("summary: %0d band items, %0d pixel results (%0d detected, %0d zero energy)",
			items_taken, results_seen, det_pixels, zero_pixels);
		$display("summary: %0d register writes over %0d random phases, %0d mismatches",
			cfg_writes, phase, mismatches);
		if (mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	// run limit
	initial begin
		#6_000_000;
		$display("timeout with %0d items taken, %0d results seen", items_taken, results_seen);
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
